/* design/pil_pkg.sv */
// Shared types and constants for the positional item list.
// Holds the transfer payload structs, the entry RAM request struct and the sequencer states.
// No dependencies.
package pil_pkg;

    localparam int CAPACITY = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 6;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_FIND   = 2'd2,
        REQ_SWAP   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_RANGE    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [POS_W-1:0] position;
        logic [4:0]       second_position;
        logic [7:0]       item_id;
        logic [7:0]       item_state;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] found_position;
        logic [5:0] list_length;
    } out_item_t;

    typedef struct packed {
        logic [7:0] ent_id;
        logic [7:0] ent_state;
    } entry_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        entry_t            wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } mem_req_t;

    typedef enum logic [3:0] {
        SQ_IDLE,
        SQ_CHECK,
        SQ_MOVE_RD,
        SQ_MOVE_WR,
        SQ_PLACE,
        SQ_FIND_RD,
        SQ_FIND_CMP,
        SQ_SWAP_RD_A,
        SQ_SWAP_RD_B,
        SQ_SWAP_WR_A,
        SQ_SWAP_WR_B,
        SQ_RESULT
    } seq_state_t;

endpackage

/* design/pil_mem.sv */
// Entry store: CAPACITY words of id and state, one write and one registered read per cycle.
// Depends on pil_pkg.
module pil_mem (
    input  logic              aclk,
    input  pil_pkg::mem_req_t req,
    output pil_pkg::entry_t   rd_data
);
    import pil_pkg::*;

    entry_t mem_array [CAPACITY];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem_array[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= mem_array[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/pil_ctrl.sv */
// Request sequencer: range checks, entry shifting, search and swap over the entry store.
// One shared pointer step unit drives every loop. Depends on pil_pkg.
module pil_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_fire,
    input  pil_pkg::in_item_t   in_item,
    output logic                idle,
    output logic                res_valid,
    input  logic                res_ready,
    output pil_pkg::out_item_t  res_item,
    output pil_pkg::mem_req_t   mem_req,
    input  pil_pkg::entry_t     rd_data
);
    import pil_pkg::*;

    seq_state_t        state_reg, state_next;
    in_item_t          req_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  ptr_reg;
    entry_t            hold_reg;
    status_t           status_reg;
    logic [4:0]        pos_reg;

    logic [CNT_W-1:0]  ptr_step;
    logic [CMP_W-1:0]  p0_w, p1_w, cnt_w, ptr_w, step_w;
    logic              is_insert;
    logic              move_more;
    logic              swap_bad;
    logic              key_hit;
    entry_t            key;

    assign is_insert = (req_t'(req_reg.req_type) == REQ_INSERT);

    // Shared step unit: down for insert, up for everything else
    assign ptr_step = is_insert ? (ptr_reg - 1'b1) : (ptr_reg + 1'b1);

    assign p0_w   = CMP_W'(req_reg.position);
    assign p1_w   = CMP_W'(req_reg.second_position);
    assign cnt_w  = CMP_W'(count_reg);
    assign ptr_w  = CMP_W'(ptr_reg);
    assign step_w = CMP_W'(ptr_step);

    assign move_more = is_insert ? (ptr_w > p0_w) : (step_w < cnt_w);
    assign swap_bad  = (p0_w >= cnt_w) || (p1_w >= cnt_w) || (p0_w == p1_w);
    assign key       = '{ent_id: req_reg.item_id, ent_state: req_reg.item_state};
    assign key_hit   = (rd_data == key);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            SQ_IDLE: begin
                if (in_fire) begin
                    state_next = SQ_CHECK;
                end
            end
            SQ_CHECK: begin
                case (req_t'(req_reg.req_type))
                    REQ_INSERT: begin
                        if (p0_w > cnt_w || cnt_w >= CMP_W'(CAPACITY)) begin
                            state_next = SQ_RESULT;
                        end else begin
                            state_next = SQ_MOVE_RD;
                        end
                    end
                    REQ_REMOVE: begin
                        if (p0_w >= cnt_w) begin
                            state_next = SQ_RESULT;
                        end else begin
                            state_next = SQ_MOVE_RD;
                        end
                    end
                    REQ_FIND: state_next = SQ_FIND_RD;
                    REQ_SWAP: state_next = swap_bad ? SQ_RESULT : SQ_SWAP_RD_A;
                    default:  state_next = SQ_RESULT;
                endcase
            end
            SQ_MOVE_RD: begin
                if (move_more) begin
                    state_next = SQ_MOVE_WR;
                end else if (is_insert) begin
                    state_next = SQ_PLACE;
                end else begin
                    state_next = SQ_RESULT;
                end
            end
            SQ_MOVE_WR:   state_next = SQ_MOVE_RD;
            SQ_PLACE:     state_next = SQ_RESULT;
            SQ_FIND_RD:   state_next = (ptr_w < cnt_w) ? SQ_FIND_CMP : SQ_RESULT;
            SQ_FIND_CMP:  state_next = key_hit ? SQ_RESULT : SQ_FIND_RD;
            SQ_SWAP_RD_A: state_next = SQ_SWAP_RD_B;
            SQ_SWAP_RD_B: state_next = SQ_SWAP_WR_A;
            SQ_SWAP_WR_A: state_next = SQ_SWAP_WR_B;
            SQ_SWAP_WR_B: state_next = SQ_RESULT;
            SQ_RESULT: begin
                if (res_ready) begin
                    state_next = SQ_IDLE;
                end
            end
            default: state_next = SQ_IDLE;
        endcase
    end

    // Outputs and entry store requests
    always_comb begin
        idle      = 1'b0;
        res_valid = 1'b0;
        mem_req   = '0;
        case (state_reg)
            SQ_IDLE: idle = 1'b1;
            SQ_MOVE_RD: begin
                mem_req.rd_en   = move_more;
                mem_req.rd_addr = ptr_step[ADDR_W-1:0];
            end
            SQ_MOVE_WR: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = ptr_reg[ADDR_W-1:0];
                mem_req.wr_data = rd_data;
            end
            SQ_PLACE: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = req_reg.position[ADDR_W-1:0];
                mem_req.wr_data = key;
            end
            SQ_FIND_RD: begin
                mem_req.rd_en   = (ptr_w < cnt_w);
                mem_req.rd_addr = ptr_reg[ADDR_W-1:0];
            end
            SQ_SWAP_RD_A: begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = req_reg.position[ADDR_W-1:0];
            end
            SQ_SWAP_RD_B: begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = ADDR_W'(req_reg.second_position);
            end
            SQ_SWAP_WR_A: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = req_reg.position[ADDR_W-1:0];
                mem_req.wr_data = rd_data;
            end
            SQ_SWAP_WR_B: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = ADDR_W'(req_reg.second_position);
                mem_req.wr_data = hold_reg;
            end
            SQ_RESULT: res_valid = 1'b1;
            default: ;
        endcase
    end

    assign res_item = '{status:         status_reg,
                        found_position: pos_reg,
                        list_length:    6'(count_reg)};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SQ_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == SQ_PLACE) begin
                count_reg <= count_reg + 1'b1;
            end else if (state_reg == SQ_MOVE_RD && !move_more && !is_insert) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            SQ_IDLE: begin
                if (in_fire) begin
                    req_reg <= in_item;
                end
            end
            SQ_CHECK: begin
                pos_reg <= '0;
                case (req_t'(req_reg.req_type))
                    REQ_INSERT: begin
                        ptr_reg <= count_reg;
                        if (p0_w > cnt_w) begin
                            status_reg <= ST_RANGE;
                        end else if (cnt_w >= CMP_W'(CAPACITY)) begin
                            status_reg <= ST_FULL;
                        end else begin
                            status_reg <= ST_DONE;
                        end
                    end
                    REQ_REMOVE: begin
                        ptr_reg <= CNT_W'(req_reg.position);
                        if (p0_w >= cnt_w) begin
                            status_reg <= ST_RANGE;
                        end else begin
                            status_reg <= ST_DONE;
                        end
                    end
                    REQ_FIND: begin
                        ptr_reg    <= '0;
                        status_reg <= ST_DONE;
                    end
                    REQ_SWAP: begin
                        if (swap_bad) begin
                            status_reg <= ST_RANGE;
                        end else begin
                            status_reg <= ST_DONE;
                        end
                    end
                    default: status_reg <= ST_RANGE;
                endcase
            end
            SQ_MOVE_WR: ptr_reg <= ptr_step;
            SQ_FIND_RD: begin
                if (ptr_w >= cnt_w) begin
                    status_reg <= ST_NOTFOUND;
                end
            end
            SQ_FIND_CMP: begin
                if (key_hit) begin
                    pos_reg <= 5'(ptr_reg);
                end else begin
                    ptr_reg <= ptr_step;
                end
            end
            SQ_SWAP_WR_A: hold_reg <= hold_reg;
            SQ_SWAP_RD_B: hold_reg <= rd_data;
            default: ;
        endcase
    end

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        CNT_W'(CAPACITY) >= count_reg)
        else $error("entry count above capacity");

    a_count_moves_only_on_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != $past(count_reg)) |->
            ($past(state_reg) == SQ_PLACE || $past(state_reg) == SQ_MOVE_RD))
        else $error("entry count changed outside a commit step");

    a_write_in_write_states: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_req.wr_en |-> (state_reg == SQ_MOVE_WR || state_reg == SQ_PLACE ||
                           state_reg == SQ_SWAP_WR_A || state_reg == SQ_SWAP_WR_B))
        else $error("entry store written outside a write step");

    a_found_below_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && req_t'(req_reg.req_type) == REQ_FIND && status_reg == ST_DONE)
            |-> (CNT_W'(pos_reg) < count_reg))
        else $error("find reports a position beyond the list");

endmodule

/* design/positional_item_list.sv */
// Channel    | Direction | Handshake          | Payload
// s_ (item)  | in        | s_valid / s_ready  | s_data : in_item_t (request)
// m_ (item)  | out       | m_valid / m_ready  | m_data : out_item_t (status, position, length)
//
// One request at a time; s_ready is high only while the sequencer is idle.
// Every request passes a check step, then the result step; rejected requests go straight
// from one to the other. Insert and remove shift entries with a read step and a write
// step per entry (insert then places the new entry), find spends a read step and a compare
// step per entry, and swap reads both positions and then writes them back crosswise.
// Reset (aresetn, synchronous) empties the list; stored entries are left as they are.
// The result register lets a new transfer be taken while the previous result waits on m_ready.
module positional_item_list (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pil_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output pil_pkg::out_item_t  m_data
);
    import pil_pkg::*;

    logic      ctrl_idle;
    logic      res_valid;
    logic      res_ready;
    out_item_t res_item;
    mem_req_t  mem_req;
    entry_t    rd_data;
    logic      m_valid_reg;
    out_item_t m_data_reg;

    assign s_ready   = ctrl_idle;
    assign res_ready = !m_valid_reg || m_ready;

    pil_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (s_valid && s_ready),
        .in_item   (s_data),
        .idle      (ctrl_idle),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item),
        .mem_req   (mem_req),
        .rd_data   (rd_data)
    );

    pil_mem u_mem (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    // Output register: load on result handoff, drop on downstream transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_data_reg <= res_item;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
